FILE: hw/rtl/pcode_stack_machine_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the P-code stack machine
// Implication forms used by pcsm_ctrl, the one module that carries checks.
// ----------------------------------------------------------------------------
`ifndef PCODE_STACK_MACHINE_TOP_ASSERT_SVH
`define PCODE_STACK_MACHINE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pcsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_pkg
// Constants, command and status types and helpers for the stack machine.
// ----------------------------------------------------------------------------
package pcsm_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int SAW         = $clog2(STACK_DEPTH);
    localparam int PROG_DEPTH  = 1024;
    localparam int PCW         = $clog2(PROG_DEPTH);
    localparam int MAX_LEVEL   = 15;
    localparam int LVW         = 4;
    localparam int WW          = 32;
    localparam int EW          = WW + 2;

    localparam int OPR_RET     = 0;
    localparam int OPR_NEG     = 1;
    localparam int OPR_ADD     = 2;
    localparam int OPR_SUB     = 3;
    localparam int OPR_MUL     = 4;
    localparam int OPR_DIV     = 5;
    localparam int OPR_ODD     = 6;
    localparam int OPR_EQ      = 8;
    localparam int OPR_NE      = 9;
    localparam int OPR_LT      = 10;
    localparam int OPR_GE      = 11;
    localparam int OPR_GT      = 12;
    localparam int OPR_LE      = 13;
    localparam int OPR_PRINT   = 14;
    localparam int OPR_NEWLINE = 15;
    localparam int OPR_READ    = 16;

    typedef enum logic [2:0] {
        F_LIT, F_LOD, F_STO, F_CAL, F_INT, F_JMP, F_JPC, F_OPR
    } t_func;

    typedef enum logic [2:0] {
        K_RET, K_NEG, K_ODD, K_BIN, K_PRINT, K_NL, K_READ, K_NONE
    } t_opr_kind;

    typedef enum logic [2:0] {
        RD_NONE, RD_BT, RD_ADDR, RD_TOP, RD_TOPM1, RD_RET, RD_DYN
    } t_rd_sel;

    typedef enum logic [3:0] {
        WR_NONE, WR_PUSH_A, WR_PUSH_RD, WR_PUSH_IN, WR_ADDR,
        WR_CAL1, WR_CAL2, WR_CAL3, WR_TOP_UN, WR_TOPM1_RES
    } t_wr_sel;

    typedef enum logic [2:0] {
        LAT_NONE, LAT_WALK, LAT_X, LAT_Y, LAT_ALU, LAT_DIV
    } t_lat_sel;

    typedef enum logic [2:0] {T_KEEP, T_INC, T_DEC, T_ADD, T_RET} t_tsel;
    typedef enum logic [1:0] {B_KEEP, B_CAL, B_RET} t_bsel;
    typedef enum logic [1:0] {P_INC, P_A, P_RET} t_psel;

    typedef enum logic [4:0] {
        S_IDLE, S_WALK, S_WALK_W, S_EXEC, S_LOD_W, S_STO_W, S_CAL2, S_CAL3,
        S_JPC_W, S_RET1, S_RET2, S_RET3, S_UN_W, S_BIN1, S_BIN2, S_BIN3,
        S_DIV, S_BIN_WR, S_PR_W
    } t_state;

    typedef struct packed {
        logic     load;
        t_rd_sel  rd;
        t_wr_sel  wr;
        t_lat_sel lat;
        logic     div_start;
        logic     commit;
        logic     fault;
        logic     pv;
        logic     pn;
        t_tsel    tsel;
        t_bsel    bsel;
        t_psel    psel;
    } t_dp_cmd;

    typedef struct packed {
        t_func     func;
        t_opr_kind kind;
        logic      is_div;
        logic      lev_bad;
        logic      cnt_zero;
        logic      bt_ok;
        logic      addr_ok;
        logic      t_inc_ok;
        logic      t_dec_ok;
        logic      t3_ok;
        logic      tadd_ok;
        logic      a_prog_ok;
        logic      ret_ok;
        logic      np_ok;
        logic      nb_ok;
        logic      rd_zero;
        logic      y_zero;
        logic      div_busy;
        logic      out_full;
    } t_dp_status;

    function automatic logic signed [EW-1:0] ext_word(input logic [WW-1:0] v);
        return $signed({{(EW-WW){v[WW-1]}}, v});
    endfunction

    function automatic logic signed [EW-1:0] ext_idx(input logic [SAW-1:0] v);
        return $signed({{(EW-SAW){1'b0}}, v});
    endfunction

    function automatic logic in_stack(input logic signed [EW-1:0] x);
        return (x >= 0) && (x < EW'(STACK_DEPTH));
    endfunction

    function automatic logic in_prog(input logic signed [EW-1:0] x);
        return (x >= 0) && (x < EW'(PROG_DEPTH));
    endfunction

    // Entries one and two come out of reset holding 1.
    function automatic logic [WW-1:0] stack_reset_val(input logic [SAW-1:0] idx);
        return ((idx == SAW'(1)) || (idx == SAW'(2))) ? WW'(1) : '0;
    endfunction

endpackage

FILE: hw/rtl/pcsm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pcsm_div
    import pcsm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_dividend,
    input  logic [WW-1:0] i_divisor,
    output logic          o_busy,
    output logic [WW-1:0] o_quot
);

    localparam int CW = $clog2(WW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [WW-1:0] r_rem;
    logic [WW-1:0] r_quo;
    logic [WW-1:0] r_dvs;
    logic          r_neg;
    logic [WW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[WW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CW'(1);
            r_busy <= (r_cnt != CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[WW-1] ? (WW'(0) - i_dividend) : i_dividend;
            r_dvs <= i_divisor[WW-1] ? (WW'(0) - i_divisor) : i_divisor;
            r_neg <= i_dividend[WW-1] ^ i_divisor[WW-1];
        end else if (r_busy) begin
            r_rem <= fits ? WW'(trial - {1'b0, r_dvs}) : trial[WW-1:0];
            r_quo <= {r_quo[WW-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? (WW'(0) - r_quo) : r_quo;

endmodule

FILE: hw/rtl/pcsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_datapath
// Stack memory, machine registers, ALU, range checks and result register.
// ----------------------------------------------------------------------------
module pcsm_datapath
    import pcsm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    input  logic [2:0]     i_func,
    input  logic [LVW-1:0] i_level,
    input  logic [WW-1:0]  i_operand,
    input  logic [WW-1:0]  i_read_value,
    input  logic           i_out_ready,
    output t_dp_status     o_st,
    output logic           o_out_valid,
    output logic [PCW-1:0] o_next_pc,
    output logic           o_print_valid,
    output logic           o_print_newline,
    output logic [WW-1:0]  o_print_value,
    output logic           o_halted,
    output logic           o_fault
);

    logic [WW-1:0]    mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_valid;

    t_func            r_func;
    logic [LVW-1:0]   r_lev;
    logic [WW-1:0]    r_a;
    logic [WW-1:0]    r_rdv;
    logic [SAW-1:0]   r_t;
    logic [SAW-1:0]   r_b;
    logic [PCW-1:0]   r_pc;
    logic [WW-1:0]    r_bt;
    logic [LVW-1:0]   r_cnt;
    logic [WW-1:0]    r_x;
    logic [WW-1:0]    r_y;
    logic [WW-1:0]    r_r;
    logic [WW-1:0]    r_rdata;

    logic             r_ov;
    logic [PCW-1:0]   r_onpc;
    logic             r_opv;
    logic             r_opn;
    logic [WW-1:0]    r_opval;
    logic             r_ohalt;
    logic             r_ofault;

    logic signed [EW-1:0] t_e, b_e, addr_e, tadd_e;
    logic [SAW-1:0]   ra, wa;
    logic [WW-1:0]    wd, alu_r, div_q, prod;
    logic             wen;
    logic [PCW-1:0]   p_inc;
    t_opr_kind        kind;
    logic             div_busy;
    logic [SAW-1:0]   n_t, n_b;
    logic [PCW-1:0]   n_p;

    assign t_e    = ext_idx(r_t);
    assign b_e    = ext_idx(r_b);
    assign addr_e = ext_word(r_bt) + ext_word(r_a);
    assign tadd_e = t_e + ext_word(r_a);
    assign p_inc  = (r_pc == PCW'(PROG_DEPTH - 1)) ? '0 : r_pc + PCW'(1);
    assign prod   = WW'(r_x * r_y);

    always_comb begin
        if (r_a == WW'(OPR_RET)) begin
            kind = K_RET;
        end else if (r_a == WW'(OPR_NEG)) begin
            kind = K_NEG;
        end else if (r_a == WW'(OPR_ODD)) begin
            kind = K_ODD;
        end else if (($signed(r_a) >= OPR_ADD && $signed(r_a) <= OPR_DIV)
                  || ($signed(r_a) >= OPR_EQ && $signed(r_a) <= OPR_LE)) begin
            kind = K_BIN;
        end else if (r_a == WW'(OPR_PRINT)) begin
            kind = K_PRINT;
        end else if (r_a == WW'(OPR_NEWLINE)) begin
            kind = K_NL;
        end else if (r_a == WW'(OPR_READ)) begin
            kind = K_READ;
        end else begin
            kind = K_NONE;
        end
    end

    always_comb begin
        case (r_a)
            WW'(OPR_ADD): alu_r = r_x + r_y;
            WW'(OPR_SUB): alu_r = r_x - r_y;
            WW'(OPR_MUL): alu_r = prod;
            WW'(OPR_EQ):  alu_r = WW'(r_x == r_y);
            WW'(OPR_NE):  alu_r = WW'(r_x != r_y);
            WW'(OPR_LT):  alu_r = WW'($signed(r_x) < $signed(r_y));
            WW'(OPR_GE):  alu_r = WW'($signed(r_x) >= $signed(r_y));
            WW'(OPR_GT):  alu_r = WW'($signed(r_x) > $signed(r_y));
            default:      alu_r = WW'($signed(r_x) <= $signed(r_y));
        endcase
    end

    pcsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_x),
        .i_divisor  (r_y),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    always_comb begin
        case (i_cmd.rd)
            RD_BT:    ra = r_bt[SAW-1:0];
            RD_ADDR:  ra = addr_e[SAW-1:0];
            RD_TOP:   ra = r_t;
            RD_TOPM1: ra = r_t - SAW'(1);
            RD_RET:   ra = r_b + SAW'(2);
            RD_DYN:   ra = r_b + SAW'(1);
            default:  ra = r_t;
        endcase
    end

    always_comb begin
        wen = 1'b1;
        wa  = r_t + SAW'(1);
        wd  = r_a;
        case (i_cmd.wr)
            WR_PUSH_A:  wd = r_a;
            WR_PUSH_RD: wd = r_rdata;
            WR_PUSH_IN: wd = r_rdv;
            WR_ADDR: begin
                wa = addr_e[SAW-1:0];
                wd = r_rdata;
            end
            WR_CAL1:    wd = r_bt;
            WR_CAL2: begin
                wa = r_t + SAW'(2);
                wd = WW'(r_b);
            end
            WR_CAL3: begin
                wa = r_t + SAW'(3);
                wd = WW'(p_inc);
            end
            WR_TOP_UN: begin
                wa = r_t;
                wd = (kind == K_NEG) ? (WW'(0) - r_rdata) : WW'(r_rdata[0]);
            end
            WR_TOPM1_RES: begin
                wa = r_t - SAW'(1);
                wd = r_r;
            end
            default:    wen = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[wa] <= wd;
        end
        if (i_cmd.rd != RD_NONE) begin
            r_rdata <= r_valid[ra] ? mem[ra] : stack_reset_val(ra);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wen) begin
            r_valid[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_lev  <= i_level;
            r_a    <= i_operand;
            r_rdv  <= i_read_value;
            r_bt   <= WW'(r_b);
            r_cnt  <= i_level;
        end else if (i_cmd.lat == LAT_WALK) begin
            r_bt  <= r_rdata;
            r_cnt <= r_cnt - LVW'(1);
        end
        case (i_cmd.lat)
            LAT_X:   r_x <= r_rdata;
            LAT_Y:   r_y <= r_rdata;
            LAT_ALU: r_r <= alu_r;
            LAT_DIV: r_r <= div_q;
            default: r_r <= r_r;
        endcase
    end

    always_comb begin
        case (i_cmd.tsel)
            T_INC:   n_t = r_t + SAW'(1);
            T_DEC:   n_t = r_t - SAW'(1);
            T_ADD:   n_t = tadd_e[SAW-1:0];
            T_RET:   n_t = r_b - SAW'(1);
            default: n_t = r_t;
        endcase
        case (i_cmd.bsel)
            B_CAL:   n_b = r_t + SAW'(1);
            B_RET:   n_b = r_y[SAW-1:0];
            default: n_b = r_b;
        endcase
        case (i_cmd.psel)
            P_A:     n_p = r_a[PCW-1:0];
            P_RET:   n_p = r_x[PCW-1:0];
            default: n_p = p_inc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t  <= '0;
            r_b  <= SAW'(1);
            r_pc <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_ov <= 1'b1;
                if (!i_cmd.fault) begin
                    r_t  <= n_t;
                    r_b  <= n_b;
                    r_pc <= n_p;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ofault <= i_cmd.fault;
            r_onpc   <= i_cmd.fault ? r_pc : n_p;
            r_ohalt  <= !i_cmd.fault && (n_p == '0);
            r_opv    <= !i_cmd.fault && i_cmd.pv;
            r_opn    <= !i_cmd.fault && i_cmd.pn;
            r_opval  <= (!i_cmd.fault && i_cmd.pv && !i_cmd.pn) ? r_rdata : '0;
        end
    end

    always_comb begin
        o_st.func      = r_func;
        o_st.kind      = kind;
        o_st.is_div    = (r_a == WW'(OPR_DIV));
        o_st.lev_bad   = (int'(r_lev) > MAX_LEVEL);
        o_st.cnt_zero  = (r_cnt == '0);
        o_st.bt_ok     = in_stack(ext_word(r_bt));
        o_st.addr_ok   = in_stack(addr_e);
        o_st.t_inc_ok  = in_stack(t_e + EW'(1));
        o_st.t_dec_ok  = in_stack(t_e - EW'(1));
        o_st.t3_ok     = in_stack(t_e + EW'(3));
        o_st.tadd_ok   = in_stack(tadd_e);
        o_st.a_prog_ok = in_prog(ext_word(r_a));
        o_st.ret_ok    = in_stack(b_e - EW'(1)) && in_stack(b_e + EW'(2));
        o_st.np_ok     = in_prog(ext_word(r_x));
        o_st.nb_ok     = in_stack(ext_word(r_y));
        o_st.rd_zero   = (r_rdata == '0);
        o_st.y_zero    = (r_y == '0);
        o_st.div_busy  = div_busy;
        o_st.out_full  = r_ov && !i_out_ready;
    end

    assign o_out_valid     = r_ov;
    assign o_next_pc       = r_onpc;
    assign o_print_valid   = r_opv;
    assign o_print_newline = r_opn;
    assign o_print_value   = r_opval;
    assign o_halted        = r_ohalt;
    assign o_fault         = r_ofault;

endmodule

FILE: hw/rtl/pcsm_ctrl.sv
`timescale 1ns / 1ps
`include "pcode_stack_machine_top_assert.svh"
// ----------------------------------------------------------------------------
// pcsm_ctrl
// Instruction sequencer: steps the datapath through walk, access and commit.
// ----------------------------------------------------------------------------
module pcsm_ctrl
    import pcsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_st,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state  r_state, n_state;
    t_dp_cmd cmd;
    logic    do_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        do_fault = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                if (!(i_st.func == F_LOD || i_st.func == F_STO || i_st.func == F_CAL)) begin
                    n_state = S_EXEC;
                end else if (i_st.lev_bad) begin
                    do_fault = 1'b1;
                end else if (i_st.cnt_zero) begin
                    n_state = S_EXEC;
                end else if (!i_st.bt_ok) begin
                    do_fault = 1'b1;
                end else begin
                    cmd.rd  = RD_BT;
                    n_state = S_WALK_W;
                end
            end
            S_WALK_W: begin
                cmd.lat = LAT_WALK;
                n_state = S_WALK;
            end
            S_EXEC: begin
                case (i_st.func)
                    F_LIT: begin
                        if (i_st.t_inc_ok) begin
                            cmd.wr     = WR_PUSH_A;
                            cmd.commit = 1'b1;
                            cmd.tsel   = T_INC;
                        end else begin
                            do_fault = 1'b1;
                        end
                    end
                    F_LOD: begin
                        if (i_st.addr_ok && i_st.t_inc_ok) begin
                            cmd.rd  = RD_ADDR;
                            n_state = S_LOD_W;
                        end else begin
                            do_fault = 1'b1;
                        end
                    end
                    F_STO: begin
                        if (i_st.addr_ok && i_st.t_dec_ok) begin
                            cmd.rd  = RD_TOP;
                            n_state = S_STO_W;
                        end else begin
                            do_fault = 1'b1;
                        end
                    end
                    F_CAL: begin
                        if (i_st.t3_ok && i_st.a_prog_ok) begin
                            cmd.wr  = WR_CAL1;
                            n_state = S_CAL2;
                        end else begin
                            do_fault = 1'b1;
                        end
                    end
                    F_INT: begin
                        if (i_st.tadd_ok) begin
                            cmd.commit = 1'b1;
                            cmd.tsel   = T_ADD;
                        end else begin
                            do_fault = 1'b1;
                        end
                    end
                    F_JMP: begin
                        if (i_st.a_prog_ok) begin
                            cmd.commit = 1'b1;
                            cmd.psel   = P_A;
                        end else begin
                            do_fault = 1'b1;
                        end
                    end
                    F_JPC: begin
                        if (i_st.t_dec_ok) begin
                            cmd.rd  = RD_TOP;
                            n_state = S_JPC_W;
                        end else begin
                            do_fault = 1'b1;
                        end
                    end
                    default: begin
                        case (i_st.kind)
                            K_RET: begin
                                if (i_st.ret_ok) begin
                                    cmd.rd  = RD_RET;
                                    n_state = S_RET1;
                                end else begin
                                    do_fault = 1'b1;
                                end
                            end
                            K_NEG, K_ODD: begin
                                cmd.rd  = RD_TOP;
                                n_state = S_UN_W;
                            end
                            K_BIN: begin
                                if (i_st.t_dec_ok) begin
                                    cmd.rd  = RD_TOPM1;
                                    n_state = S_BIN1;
                                end else begin
                                    do_fault = 1'b1;
                                end
                            end
                            K_PRINT: begin
                                if (i_st.t_dec_ok) begin
                                    cmd.rd  = RD_TOP;
                                    n_state = S_PR_W;
                                end else begin
                                    do_fault = 1'b1;
                                end
                            end
                            K_NL: begin
                                cmd.commit = 1'b1;
                                cmd.pv     = 1'b1;
                                cmd.pn     = 1'b1;
                            end
                            K_READ: begin
                                if (i_st.t_inc_ok) begin
                                    cmd.wr     = WR_PUSH_IN;
                                    cmd.commit = 1'b1;
                                    cmd.tsel   = T_INC;
                                end else begin
                                    do_fault = 1'b1;
                                end
                            end
                            default: begin
                                cmd.commit = 1'b1;
                            end
                        endcase
                    end
                endcase
            end
            S_LOD_W: begin
                cmd.wr     = WR_PUSH_RD;
                cmd.commit = 1'b1;
                cmd.tsel   = T_INC;
            end
            S_STO_W: begin
                cmd.wr     = WR_ADDR;
                cmd.commit = 1'b1;
                cmd.tsel   = T_DEC;
            end
            S_CAL2: begin
                cmd.wr  = WR_CAL2;
                n_state = S_CAL3;
            end
            S_CAL3: begin
                cmd.wr     = WR_CAL3;
                cmd.commit = 1'b1;
                cmd.bsel   = B_CAL;
                cmd.psel   = P_A;
            end
            S_JPC_W: begin
                if (!i_st.rd_zero) begin
                    cmd.commit = 1'b1;
                    cmd.tsel   = T_DEC;
                end else if (i_st.a_prog_ok) begin
                    cmd.commit = 1'b1;
                    cmd.tsel   = T_DEC;
                    cmd.psel   = P_A;
                end else begin
                    do_fault = 1'b1;
                end
            end
            S_RET1: begin
                cmd.lat = LAT_X;
                cmd.rd  = RD_DYN;
                n_state = S_RET2;
            end
            S_RET2: begin
                cmd.lat = LAT_Y;
                n_state = S_RET3;
            end
            S_RET3: begin
                if (i_st.np_ok && i_st.nb_ok) begin
                    cmd.commit = 1'b1;
                    cmd.tsel   = T_RET;
                    cmd.bsel   = B_RET;
                    cmd.psel   = P_RET;
                end else begin
                    do_fault = 1'b1;
                end
            end
            S_UN_W: begin
                cmd.wr     = WR_TOP_UN;
                cmd.commit = 1'b1;
            end
            S_BIN1: begin
                cmd.lat = LAT_X;
                cmd.rd  = RD_TOP;
                n_state = S_BIN2;
            end
            S_BIN2: begin
                cmd.lat = LAT_Y;
                n_state = S_BIN3;
            end
            S_BIN3: begin
                if (!i_st.is_div) begin
                    cmd.lat = LAT_ALU;
                    n_state = S_BIN_WR;
                end else if (i_st.y_zero) begin
                    do_fault = 1'b1;
                end else begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_st.div_busy) begin
                    cmd.lat = LAT_DIV;
                    n_state = S_BIN_WR;
                end
            end
            S_BIN_WR: begin
                cmd.wr     = WR_TOPM1_RES;
                cmd.commit = 1'b1;
                cmd.tsel   = T_DEC;
            end
            S_PR_W: begin
                cmd.commit = 1'b1;
                cmd.pv     = 1'b1;
                cmd.tsel   = T_DEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_fault) begin
            cmd.commit = 1'b1;
            cmd.fault  = 1'b1;
        end
        if (cmd.commit) begin
            n_state = S_IDLE;
        end
        // Hold the whole step while the previous result has not been taken.
        if (cmd.commit && i_st.out_full) begin
            cmd     = '0;
            n_state = r_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == S_IDLE);

    `PCSM_ASSERT_NEXT(a_leave_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "accepted beat did not start execution")
    `PCSM_ASSERT_NOW(a_commit_room, i_clk, i_rst_n, cmd.commit, !i_st.out_full, "commit while result register full")
    `PCSM_ASSERT_NOW(a_fault_quiet, i_clk, i_rst_n, cmd.commit && cmd.fault, cmd.wr == WR_NONE && !cmd.pv, "faulting step writes or prints")

endmodule

FILE: hw/rtl/pcode_stack_machine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcode_stack_machine_top
// P-code stack machine: executes one instruction per input beat.
// ----------------------------------------------------------------------------
// Usage: each slave beat carries one instruction, fetched by the user from the
// address last reported as next_pc (0 after reset), plus the value consumed by
// a read operation. Each instruction yields exactly one master beat with the
// next fetch address, print information, halted and fault flags.
// Loads, stores and calls first walk the static links, one stack read per level;
// a divide waits on the one-bit-per-cycle divider. One instruction is in flight
// at a time, so a new beat is taken only once the last has committed; the
// sequencer and the single stack read port set the pace.
// Reset restores the stack to its initial contents at once (per-entry valid
// bits), with top 0, frame base 1 and program counter 0. If the receiver
// stalls, the result holds in the output register, the next beat may still be
// accepted, and it finishes all but its commit until the register frees.
// ----------------------------------------------------------------------------
module pcode_stack_machine_top
    import pcsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // func[2:0], level[6:3], operand[38:7], read_value[70:39], zero pad [71]
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // next_pc[9:0], print_valid[10], print_newline[11], print_value[43:12],
    // halted[44], fault[45], zero pad [47:46]
    output logic [47:0] o_m_axis_tdata
);

    t_dp_cmd        cmd;
    t_dp_status     st;
    logic [PCW-1:0] next_pc;
    logic           pv, pn, halted, fault;
    logic [WW-1:0]  pval;

    pcsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_st       (st),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    pcsm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_func          (i_s_axis_tdata[2:0]),
        .i_level         (i_s_axis_tdata[6:3]),
        .i_operand       (i_s_axis_tdata[38:7]),
        .i_read_value    (i_s_axis_tdata[70:39]),
        .i_out_ready     (i_m_axis_tready),
        .o_st            (st),
        .o_out_valid     (o_m_axis_tvalid),
        .o_next_pc       (next_pc),
        .o_print_valid   (pv),
        .o_print_newline (pn),
        .o_print_value   (pval),
        .o_halted        (halted),
        .o_fault         (fault)
    );

    assign o_m_axis_tdata = {2'b00, fault, halted, pval, pn, pv, next_pc};

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the P-code stack machine. A behavioral model predicts
// every result beat; directed programs cover each function, the divide and the
// fault cases, then random programs run with idle bursts on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import pcsm_pkg::*;

    // Packed from the most significant bit down, so fault lands in bit 45.
    typedef struct packed {
        logic        fault;
        logic        halted;
        logic [31:0] print_value;
        logic        print_newline;
        logic        print_valid;
        logic [9:0]  next_pc;
    } t_outcome;

    class pcode_scoreboard;
        logic [31:0] mem [STACK_DEPTH];
        int          top;
        int          base;
        int          pc;
        t_outcome    pending [$];
        int          errors;

        function void clear_state();
            foreach (mem[i]) mem[i] = '0;
            mem[1] = 32'd1;
            mem[2] = 32'd1;
            top = 0;
            base = 1;
            pc = 0;
            errors = 0;
        endfunction

        function bit in_stk(longint x);
            return x >= 0 && x < STACK_DEPTH;
        endfunction

        function bit in_pgm(longint x);
            return x >= 0 && x < PROG_DEPTH;
        endfunction

        // Follows static links; returns 0 on a bad level or address.
        function bit chase_links(int lev, output longint res);
            longint bt;
            bt = base;
            res = 0;
            if (lev > MAX_LEVEL) return 0;
            for (int i = 0; i < lev; i++) begin
                if (!in_stk(bt)) return 0;
                bt = longint'($signed(mem[bt]));
            end
            res = bt;
            return 1;
        endfunction

        function void note_instruction(t_func fn, int lev, logic [31:0] opd,
                                       logic [31:0] rdv);
            longint t, b, p, bs, addr, a, nt, np, nb;
            bit ok, pv, pn;
            logic [31:0] pval, x, y, r;
            t_outcome o;
            t = top; b = base; p = (pc + 1) % PROG_DEPTH;
            a = longint'($signed(opd));
            ok = 1; pv = 0; pn = 0; pval = '0; bs = 0;
            case (fn)
                F_LIT: if (!in_stk(t + 1)) ok = 0; else begin
                    t++; mem[t] = opd;
                end
                F_LOD: begin
                    if (!chase_links(lev, bs)) ok = 0;
                    else begin
                        addr = bs + a;
                        if (!in_stk(addr) || !in_stk(t + 1)) ok = 0;
                        else begin t++; mem[t] = mem[addr]; end
                    end
                end
                F_STO: begin
                    if (!chase_links(lev, bs)) ok = 0;
                    else begin
                        addr = bs + a;
                        if (!in_stk(addr) || !in_stk(t - 1)) ok = 0;
                        else begin mem[addr] = mem[t]; t--; end
                    end
                end
                F_CAL: begin
                    if (!chase_links(lev, bs)) ok = 0;
                    else if (!in_stk(t + 3) || !in_pgm(a)) ok = 0;
                    else begin
                        mem[t + 1] = 32'(bs);
                        mem[t + 2] = 32'(b);
                        mem[t + 3] = 32'(p);
                        b = t + 1; p = a;
                    end
                end
                F_INT: if (!in_stk(t + a)) ok = 0; else t += a;
                F_JMP: if (!in_pgm(a)) ok = 0; else p = a;
                F_JPC: begin
                    if (!in_stk(t - 1)) ok = 0;
                    else if (mem[t] == 0 && !in_pgm(a)) ok = 0;
                    else begin
                        if (mem[t] == 0) p = a;
                        t--;
                    end
                end
                default: begin
                    if (a == OPR_RET) begin
                        nt = b - 1;
                        if (!in_stk(nt) || !in_stk(nt + 3)) ok = 0;
                        else begin
                            np = longint'($signed(mem[nt + 3]));
                            nb = longint'($signed(mem[nt + 2]));
                            if (!in_pgm(np) || !in_stk(nb)) ok = 0;
                            else begin t = nt; p = np; b = nb; end
                        end
                    end else if (a == OPR_NEG) mem[t] = -mem[t];
                    else if (a == OPR_ODD) mem[t] &= 32'd1;
                    else if ((a >= OPR_ADD && a <= OPR_DIV) ||
                             (a >= OPR_EQ && a <= OPR_LE)) begin
                        if (!in_stk(t - 1)) ok = 0;
                        else begin
                            x = mem[t - 1]; y = mem[t]; r = '0;
                            case (a)
                                OPR_ADD: r = x + y;
                                OPR_SUB: r = x - y;
                                OPR_MUL: r = x * y;
                                OPR_DIV: if (y == 0) ok = 0;
                                    else if (x == 32'h8000_0000 && y == '1) r = x;
                                    else r = $signed(x) / $signed(y);
                                OPR_EQ: r = 32'(x == y);
                                OPR_NE: r = 32'(x != y);
                                OPR_LT: r = 32'($signed(x) < $signed(y));
                                OPR_GE: r = 32'($signed(x) >= $signed(y));
                                OPR_GT: r = 32'($signed(x) > $signed(y));
                                default: r = 32'($signed(x) <= $signed(y));
                            endcase
                            if (ok) begin t--; mem[t] = r; end
                        end
                    end else if (a == OPR_PRINT) begin
                        if (!in_stk(t - 1)) ok = 0;
                        else begin pv = 1; pval = mem[t]; t--; end
                    end else if (a == OPR_NEWLINE) begin
                        pv = 1; pn = 1;
                    end else if (a == OPR_READ) begin
                        if (!in_stk(t + 1)) ok = 0;
                        else begin t++; mem[t] = rdv; end
                    end
                end
            endcase
            if (ok) begin top = t; base = b; pc = p; end
            o.next_pc = 10'(pc);
            o.print_valid = ok && pv;
            o.print_newline = ok && pn;
            o.print_value = ok ? pval : '0;
            o.halted = ok && pc == 0;
            o.fault = !ok;
            pending.push_back(o);
        endfunction

        function void check_result(logic [47:0] data);
            t_outcome got, want;
            got = t_outcome'(data[45:0]);
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.next_pc != want.next_pc)
                $display("%0t: next_pc expected %0d actual %0d", $time,
                         want.next_pc, got.next_pc);
            if (got.print_valid != want.print_valid)
                $display("%0t: print_valid expected %0b actual %0b", $time,
                         want.print_valid, got.print_valid);
            if (got.print_newline != want.print_newline)
                $display("%0t: print_newline expected %0b actual %0b", $time,
                         want.print_newline, got.print_newline);
            if (got.print_value != want.print_value)
                $display("%0t: print_value expected %h actual %h", $time,
                         want.print_value, got.print_value);
            if (got.halted != want.halted)
                $display("%0t: halted expected %0b actual %0b", $time,
                         want.halted, got.halted);
            if (got.fault != want.fault)
                $display("%0t: fault expected %0b actual %0b", $time,
                         want.fault, got.fault);
            if (got != want) errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [71:0] in_data;
    logic        out_valid;
    logic        out_ready;
    logic [47:0] out_data;
    bit          calm;
    int          cycles;
    pcode_scoreboard board;

    pcode_stack_machine_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Valid stays high between back-to-back beats; it drops only for an idle
    // burst or when the sender pauses.
    task automatic send_instr(t_func fn, int lev, logic [31:0] opd,
                              logic [31:0] rdv);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {1'b0, rdv, opd, 4'(lev), fn};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_instruction(fn, lev, opd, rdv);
        @(negedge clk);
    endtask

    // Random operand, mostly small so stack addresses and targets stay legal.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 12)) - 3);
        endcase
    endfunction

    // Receiver side: random stall bursts, none in the calm tail.
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_result(out_data);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] opd;
        int          f;
        board = new();
        board.clear_state();
        cycles = 0;
        calm = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each function, the divide, the extremes and the fault cases.
        send_instr(F_LIT, 0, 32'h8000_0000, 0);
        send_instr(F_LIT, 0, 32'hffff_ffff, 0);
        send_instr(F_OPR, 0, OPR_DIV, 0);          // most negative / -1
        send_instr(F_OPR, 0, OPR_PRINT, 0);
        send_instr(F_LIT, 0, 32'h7fff_ffff, 0);
        send_instr(F_LIT, 0, 0, 0);
        send_instr(F_OPR, 0, OPR_DIV, 0);          // divide by zero
        send_instr(F_OPR, 0, OPR_READ, 32'hffff_ffff);
        send_instr(F_OPR, 0, OPR_ODD, 0);
        send_instr(F_OPR, 0, OPR_NEG, 0);
        send_instr(F_OPR, 0, OPR_NEWLINE, 0);
        send_instr(F_OPR, 0, 7, 0);                // undefined sub-operation
        send_instr(F_OPR, 0, 32'hffff_ffff, 0);
        send_instr(F_LOD, 15, 0, 0);
        send_instr(F_STO, 1, 2, 0);
        send_instr(F_CAL, 1, 1023, 0);
        send_instr(F_OPR, 0, OPR_RET, 0);
        send_instr(F_INT, 0, 127, 0);              // allocation past the stack end
        send_instr(F_LIT, 0, 5, 0);                // plain push
        send_instr(F_INT, 0, 32'h8000_0000, 0);
        send_instr(F_INT, 0, -120, 0);
        send_instr(F_JPC, 0, 1024, 0);
        send_instr(F_JMP, 0, 0, 0);                // halted
        send_instr(F_JMP, 0, 32'hffff_ffff, 0);

        // Pause until the machine has drained.
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);

        for (int n = 0; n < 450; n++) begin
            if (n == 400) calm = 1;
            opd = pick_operand();
            f = $urandom_range(0, 9);
            if (f >= 7) begin
                f = F_OPR;
                if ($urandom_range(0, 5) != 0) opd = $urandom_range(0, 17);
            end else if (f == F_INT && $urandom_range(0, 2) != 0)
                opd = $urandom_range(0, 4);
            // Keep stack depth moderate so most programs run deep.
            if (board.top > 100 && f == F_LIT) begin
                f = F_INT;
                opd = -$urandom_range(20, 60);
            end
            send_instr(t_func'(f), $urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                       : $urandom_range(0, 2), opd, $urandom());
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pcsm_pkg.sv
hw/rtl/pcsm_div.sv
hw/rtl/pcsm_datapath.sv
hw/rtl/pcsm_ctrl.sv
hw/rtl/pcode_stack_machine_top.sv
test/testbench.sv
